/* design/triangle_scanline_span_macros.svh */
// Assertion macros shared by the triangle scanline span design files.
`ifndef TRIANGLE_SCANLINE_SPAN_MACROS_SVH
`define TRIANGLE_SCANLINE_SPAN_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication checked at every rising clock edge.
`define TSS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("triangle_scanline_span assertion failed");
// Next-cycle implication checked at every rising clock edge.
`define TSS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("triangle_scanline_span assertion failed");
`else
`define TSS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TSS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* design/tss_pkg.sv */
// Shared types and constants of the triangle scanline span block.
`default_nettype none
package tss_pkg;
   // Default parameter values.
   localparam int COORD_BITS_DEF = 16;
   localparam int ATTR_BITS_DEF  = 16;

   // Width of one packed vertex slot.
   localparam int SLOT_W = 16;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_VERTEX_A = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_VERTEX_B = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_VERTEX_C = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SLOPE_AB = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SLOPE_BC = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SLOPE_AC = 3'd5;

   // Datapath widths.
   localparam int XQ_W = 50;
   localparam int D_W  = 33;
   localparam int Q_W  = 32;
   localparam int K_W  = 17;

   // How the blend coefficient is formed.
   typedef enum logic [1:0] {
      K_NORMAL = 2'b00,
      K_ZERO   = 2'b01,
      K_FULL   = 2'b10
   } kmode_type;

   typedef struct packed {
      logic signed [SLOT_W-1:0] x;
      logic signed [SLOT_W-1:0] y;
      logic [SLOT_W-1:0]        z;
      logic [SLOT_W-1:0]        l;
   } vtx_type;

   // One edge job handed to a lane.
   typedef struct packed {
      vtx_type                  p;
      vtx_type                  q;
      logic signed [SLOT_W-1:0] org_x;
      logic signed [SLOT_W-1:0] org_y;
      logic signed [31:0]       slope;
      logic signed [SLOT_W-1:0] row;
   } lane_in_type;

   // One span endpoint, x unsaturated.
   typedef struct packed {
      logic signed [XQ_W-1:0] xq;
      logic [SLOT_W-1:0]      z;
      logic [SLOT_W-1:0]      l;
   } endp_type;
endpackage
`default_nettype wire

/* design/tss_lane.sv */
// Pipelined edge lane: x at the row, blend coefficient by division and root, attribute blend.
`default_nettype none
module tss_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  tss_pkg::lane_in_type  lane_in,
   output logic                  out_valid,
   output tss_pkg::endp_type     out_ep,
   output logic signed [15:0]    out_row
);
   `include "triangle_scanline_span_macros.svh"

   localparam int DIV_STEPS = tss_pkg::Q_W;
   localparam int NLO_W     = 16;
   localparam int SQ_STEPS  = tss_pkg::Q_W / 2;
   localparam int ROOT_W    = tss_pkg::Q_W / 2;
   localparam int SQR_W     = ROOT_W + 2;
   localparam int XQ_W      = tss_pkg::XQ_W;
   localparam int D_W       = tss_pkg::D_W;

   typedef struct packed {
      logic [15:0]        pz;
      logic [15:0]        qz;
      logic [15:0]        pl;
      logic [15:0]        ql;
      logic signed [15:0] row;
   } attr_type;

   typedef struct packed {
      logic               v;
      logic signed [16:0] ex;
      logic signed [16:0] ey;
      logic signed [16:0] dyo;
      logic signed [16:0] dyp;
      logic signed [31:0] slope;
      logic signed [15:0] org_x;
      logic signed [15:0] px;
      attr_type           at;
   } s1_type;

   typedef struct packed {
      logic               v;
      logic signed [48:0] prod;
      logic [31:0]        ex2;
      logic [31:0]        ey2;
      logic [33:0]        dyp2;
      logic signed [15:0] org_x;
      logic signed [15:0] px;
      attr_type           at;
   } s2_type;

   typedef struct packed {
      logic                   v;
      logic signed [XQ_W-1:0] xq;
      logic [D_W-1:0]         d;
      logic [33:0]            dyp2;
      logic signed [15:0]     px;
      attr_type               at;
   } s3_type;

   typedef struct packed {
      logic                   v;
      logic signed [XQ_W:0]   dxq;
      logic signed [XQ_W-1:0] xq;
      logic [D_W-1:0]         d;
      logic [33:0]            dyp2;
      attr_type               at;
   } s4_type;

   typedef struct packed {
      logic                   v;
      logic                   big;
      logic [25:0]            m8;
      logic signed [XQ_W-1:0] xq;
      logic [D_W-1:0]         d;
      logic [33:0]            dyp2;
      attr_type               at;
   } s5_type;

   typedef struct packed {
      logic                   v;
      logic                   big;
      logic [51:0]            m8sq;
      logic signed [XQ_W-1:0] xq;
      logic [D_W-1:0]         d;
      logic [33:0]            dyp2;
      attr_type               at;
   } s6_type;

   typedef struct packed {
      logic                   v;
      logic                   big;
      logic [52:0]            n;
      logic signed [XQ_W-1:0] xq;
      logic [D_W-1:0]         d;
      attr_type               at;
   } s7_type;

   typedef struct packed {
      logic                   v;
      logic signed [XQ_W-1:0] xq;
      tss_pkg::kmode_type     mode;
      attr_type               at;
   } tail_type;

   typedef struct packed {
      logic [D_W-1:0]         rem;
      logic [DIV_STEPS-1:0]   q;
      logic [NLO_W-1:0]       nlo;
      logic [D_W-1:0]         d;
   } div_type;

   typedef struct packed {
      logic [SQR_W-1:0]       rem;
      logic [ROOT_W-1:0]      root;
      logic [DIV_STEPS-1:0]   r;
   } sqrt_type;

   typedef struct packed {
      logic [tss_pkg::K_W-1:0] k;
      logic signed [16:0]      dz;
      logic signed [16:0]      dl;
      tail_type                tl;
   } kst_type;

   typedef struct packed {
      logic signed [33:0] zp;
      logic signed [33:0] lp;
      tail_type           tl;
   } mul_type;

   typedef struct packed {
      logic [15:0] z;
      logic [15:0] l;
      tail_type    tl;
   } fin_type;

   s1_type   s1_in, s1_ff;
   s2_type   s2_in, s2_ff;
   s3_type   s3_in, s3_ff;
   s4_type   s4_in, s4_ff;
   s5_type   s5_in, s5_ff;
   s6_type   s6_in, s6_ff;
   s7_type   s7_in, s7_ff;
   tail_type tail_in;
   div_type  div0_in;
   tail_type tail_ff [0:DIV_STEPS+SQ_STEPS];
   div_type  div_ff  [0:DIV_STEPS];
   sqrt_type sq_ff   [0:SQ_STEPS-1];
   sqrt_type sq_src  [0:SQ_STEPS-1];
   kst_type  kst_in, kst_ff;
   mul_type  mul_in, mul_ff;
   fin_type  fin_in, fin_ff;

   // Stage 1: coordinate differences.
   always_comb begin
      s1_in.v     = in_valid;
      s1_in.ex    = 17'(lane_in.p.x) - 17'(lane_in.q.x);
      s1_in.ey    = 17'(lane_in.p.y) - 17'(lane_in.q.y);
      s1_in.dyo   = 17'(lane_in.row) - 17'(lane_in.org_y);
      s1_in.dyp   = 17'(lane_in.p.y) - 17'(lane_in.row);
      s1_in.slope = lane_in.slope;
      s1_in.org_x = lane_in.org_x;
      s1_in.px    = lane_in.p.x;
      s1_in.at.pz = lane_in.p.z;
      s1_in.at.qz = lane_in.q.z;
      s1_in.at.pl = lane_in.p.l;
      s1_in.at.ql = lane_in.q.l;
      s1_in.at.row = lane_in.row;
   end

   // Stage 2: slope product and squares.
   always_comb begin
      logic signed [33:0] exs;
      logic signed [33:0] eys;
      logic signed [34:0] dys;
      exs = 34'(s1_ff.ex) * 34'(s1_ff.ex);
      eys = 34'(s1_ff.ey) * 34'(s1_ff.ey);
      dys = 35'(s1_ff.dyp) * 35'(s1_ff.dyp);
      s2_in.v     = s1_ff.v;
      s2_in.prod  = 49'(s1_ff.slope) * 49'(s1_ff.dyo);
      s2_in.ex2   = exs[31:0];
      s2_in.ey2   = eys[31:0];
      s2_in.dyp2  = dys[33:0];
      s2_in.org_x = s1_ff.org_x;
      s2_in.px    = s1_ff.px;
      s2_in.at    = s1_ff.at;
   end

   // Stage 3: edge x in Q34.16 and squared edge length.
   always_comb begin
      s3_in.v    = s2_ff.v;
      s3_in.xq   = XQ_W'(s2_ff.prod) + (XQ_W'(s2_ff.org_x) <<< 16);
      s3_in.d    = D_W'(s2_ff.ex2) + D_W'(s2_ff.ey2);
      s3_in.dyp2 = s2_ff.dyp2;
      s3_in.px   = s2_ff.px;
      s3_in.at   = s2_ff.at;
   end

   // Stage 4: x distance from the edge start.
   always_comb begin
      s4_in.v    = s3_ff.v;
      s4_in.dxq  = ((XQ_W+1)'(s3_ff.px) <<< 16) - (XQ_W+1)'(s3_ff.xq);
      s4_in.xq   = s3_ff.xq;
      s4_in.d    = s3_ff.d;
      s4_in.dyp2 = s3_ff.dyp2;
      s4_in.at   = s3_ff.at;
   end

   // Stage 5: magnitude, far-beyond flag and coarse x distance.
   always_comb begin
      logic [XQ_W:0] mag;
      mag = s4_ff.dxq[XQ_W] ? (XQ_W+1)'(-s4_ff.dxq) : (XQ_W+1)'(s4_ff.dxq);
      s5_in.v    = s4_ff.v;
      s5_in.big  = |mag[XQ_W:34];
      s5_in.m8   = mag[33:8];
      s5_in.xq   = s4_ff.xq;
      s5_in.d    = s4_ff.d;
      s5_in.dyp2 = s4_ff.dyp2;
      s5_in.at   = s4_ff.at;
   end

   // Stage 6: square of the x distance.
   always_comb begin
      s6_in.v    = s5_ff.v;
      s6_in.big  = s5_ff.big;
      s6_in.m8sq = 52'(s5_ff.m8) * 52'(s5_ff.m8);
      s6_in.xq   = s5_ff.xq;
      s6_in.d    = s5_ff.d;
      s6_in.dyp2 = s5_ff.dyp2;
      s6_in.at   = s5_ff.at;
   end

   // Stage 7: squared partial length.
   always_comb begin
      s7_in.v   = s6_ff.v;
      s7_in.big = s6_ff.big;
      s7_in.n   = 53'(s6_ff.m8sq) + (53'(s6_ff.dyp2) << 16);
      s7_in.xq  = s6_ff.xq;
      s7_in.d   = s6_ff.d;
      s7_in.at  = s6_ff.at;
   end

   // Stage 8: special cases and divider setup.
   always_comb begin
      logic over;
      over = s7_ff.n >= (53'(s7_ff.d) << 16);
      tail_in.v  = s7_ff.v;
      tail_in.xq = s7_ff.xq;
      tail_in.at = s7_ff.at;
      if (s7_ff.d == '0) begin
         tail_in.mode = tss_pkg::K_ZERO;
      end else if (s7_ff.big || over) begin
         tail_in.mode = tss_pkg::K_FULL;
      end else begin
         tail_in.mode = tss_pkg::K_NORMAL;
      end
      div0_in.rem = s7_ff.n[D_W+15:16];
      div0_in.q   = '0;
      div0_in.nlo = s7_ff.n[NLO_W-1:0];
      div0_in.d   = s7_ff.d;
   end

   // Front stage registers; only the valid bits are reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.v <= 1'b0;
         s2_ff.v <= 1'b0;
         s3_ff.v <= 1'b0;
         s4_ff.v <= 1'b0;
         s5_ff.v <= 1'b0;
         s6_ff.v <= 1'b0;
         s7_ff.v <= 1'b0;
         tail_ff[0].v <= 1'b0;
      end else if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
         s7_ff <= s7_in;
         tail_ff[0] <= tail_in;
         div_ff[0] <= div0_in;
      end
   end

   // Restoring divider, one quotient bit per stage.
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      logic    inbit;
      div_type div_in;
      if (j < NLO_W) begin : g_lo
         assign inbit = div_ff[j].nlo[NLO_W-1-j];
      end else begin : g_zero
         assign inbit = 1'b0;
      end
      always_comb begin
         logic [D_W:0] trial;
         trial = {div_ff[j].rem, inbit};
         div_in = div_ff[j];
         if (trial >= {1'b0, div_ff[j].d}) begin
            div_in.rem = D_W'(trial - {1'b0, div_ff[j].d});
            div_in.q   = {div_ff[j].q[DIV_STEPS-2:0], 1'b1};
         end else begin
            div_in.rem = D_W'(trial);
            div_in.q   = {div_ff[j].q[DIV_STEPS-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            tail_ff[j+1].v <= 1'b0;
         end else if (en) begin
            tail_ff[j+1] <= tail_ff[j];
            div_ff[j+1]  <= div_in;
         end
      end
   end

   // Digit-by-digit square root, one root bit per stage.
   for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
      sqrt_type sq_in;
      if (i == 0) begin : g_first
         assign sq_src[i] = '{rem: '0, root: '0, r: div_ff[DIV_STEPS].q};
      end else begin : g_next
         assign sq_src[i] = sq_ff[i-1];
      end
      always_comb begin
         logic [SQR_W+1:0] shifted;
         logic [SQR_W+1:0] trial;
         shifted = {sq_src[i].rem, sq_src[i].r[DIV_STEPS-1-2*i -: 2]};
         trial   = (SQR_W+2)'({sq_src[i].root, 2'b01});
         sq_in   = sq_src[i];
         if (shifted >= trial) begin
            sq_in.rem  = SQR_W'(shifted - trial);
            sq_in.root = {sq_src[i].root[ROOT_W-2:0], 1'b1};
         end else begin
            sq_in.rem  = SQR_W'(shifted);
            sq_in.root = {sq_src[i].root[ROOT_W-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            tail_ff[DIV_STEPS+1+i].v <= 1'b0;
         end else if (en) begin
            tail_ff[DIV_STEPS+1+i] <= tail_ff[DIV_STEPS+i];
            sq_ff[i] <= sq_in;
         end
      end
   end

   // Coefficient select and attribute differences.
   always_comb begin
      tail_type tl;
      tl = tail_ff[DIV_STEPS+SQ_STEPS];
      case (tl.mode)
         tss_pkg::K_ZERO:   kst_in.k = '0;
         tss_pkg::K_FULL:   kst_in.k = tss_pkg::K_W'(1) << 16;
         tss_pkg::K_NORMAL: kst_in.k = tss_pkg::K_W'(sq_ff[SQ_STEPS-1].root);
         default:           kst_in.k = '0;
      endcase
      kst_in.dz = $signed({1'b0, tl.at.qz}) - $signed({1'b0, tl.at.pz});
      kst_in.dl = $signed({1'b0, tl.at.ql}) - $signed({1'b0, tl.at.pl});
      kst_in.tl = tl;
   end

   // Blend products.
   always_comb begin
      mul_in.zp = 34'($signed({1'b0, kst_ff.k})) * 34'(kst_ff.dz);
      mul_in.lp = 34'($signed({1'b0, kst_ff.k})) * 34'(kst_ff.dl);
      mul_in.tl = kst_ff.tl;
   end

   // Blend sums; the arithmetic shift floors as the fraction requires.
   always_comb begin
      logic signed [33:0] zs;
      logic signed [33:0] ls;
      zs = 34'($signed({1'b0, mul_ff.tl.at.pz})) + (mul_ff.zp >>> 16);
      ls = 34'($signed({1'b0, mul_ff.tl.at.pl})) + (mul_ff.lp >>> 16);
      fin_in.z  = zs[15:0];
      fin_in.l  = ls[15:0];
      fin_in.tl = mul_ff.tl;
   end

   // Back stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         kst_ff.tl.v <= 1'b0;
         mul_ff.tl.v <= 1'b0;
         fin_ff.tl.v <= 1'b0;
      end else if (en) begin
         kst_ff <= kst_in;
         mul_ff <= mul_in;
         fin_ff <= fin_in;
      end
   end

   assign out_valid = fin_ff.tl.v;
   assign out_ep    = '{xq: fin_ff.tl.xq, z: fin_ff.z, l: fin_ff.l};
   assign out_row   = fin_ff.tl.at.row;

   // In normal mode the divider remainder ends below the divisor.
   `TSS_ASSERT_IMP(a_div_rem, clock, reset, tail_ff[DIV_STEPS].v && tail_ff[DIV_STEPS].mode == tss_pkg::K_NORMAL, div_ff[DIV_STEPS].rem < div_ff[DIV_STEPS].d)
   // A blended depth lies between the two vertex depths.
   `TSS_ASSERT_IMP(a_depth_rng, clock, reset, fin_ff.tl.v, (fin_ff.z >= fin_ff.tl.at.pz && fin_ff.z <= fin_ff.tl.at.qz) || (fin_ff.z <= fin_ff.tl.at.pz && fin_ff.z >= fin_ff.tl.at.qz))
   // A blended light lies between the two vertex lights.
   `TSS_ASSERT_IMP(a_light_rng, clock, reset, fin_ff.tl.v, (fin_ff.l >= fin_ff.tl.at.pl && fin_ff.l <= fin_ff.tl.at.ql) || (fin_ff.l <= fin_ff.tl.at.pl && fin_ff.l >= fin_ff.tl.at.ql))
endmodule
`default_nettype wire

/* design/triangle_scanline_span.sv */
// Top level of the triangle scanline span block: registers, edge lanes, ordering, output.
//
// Usage: the triangle's vertices a, b and c and the x slopes of its edges a-b, b-c and a-c are
// loaded through the csr_ channel (csr_valid, csr_ready, csr_index, csr_wdata);
// csr_ready is always high; the user must write registers only while the block is idle,
// a rule the block itself leaves unchecked. Each req_ transaction carries one scanline
// row in req_scan_y. The matching rsp_ transaction carries the left and right span
// endpoints (x in Q16.16, depth and light) and the row echoed in rsp_row_out.
// Between acceptance and rsp_valid lie the 32-stage divider and 16-stage square root
// in each edge lane. One row is accepted every cycle unless the pipeline is stalled.
// Reset clears all configuration registers to zero and empties the pipeline.
// When the receiver stalls a waiting result, the whole pipeline holds and
// req_stall rises; nothing is dropped or repeated.
`default_nettype none
module triangle_scanline_span #(
   parameter int COORD_BITS = tss_pkg::COORD_BITS_DEF,
   parameter int ATTR_BITS  = tss_pkg::ATTR_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [15:0]                  req_scan_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [31:0]                  rsp_left_x,
   output logic [15:0]                         rsp_left_depth,
   output logic [15:0]                         rsp_left_light,
   output logic signed [31:0]                  rsp_right_x,
   output logic [15:0]                         rsp_right_depth,
   output logic [15:0]                         rsp_right_light,
   output logic signed [15:0]                  rsp_row_out,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tss_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [63:0]                         csr_wdata
);
   `include "triangle_scanline_span_macros.svh"

   localparam int CW = (COORD_BITS > tss_pkg::SLOT_W) ? tss_pkg::SLOT_W : COORD_BITS;
   localparam int AW = (ATTR_BITS > tss_pkg::SLOT_W) ? tss_pkg::SLOT_W : ATTR_BITS;
   localparam int XQ_W = tss_pkg::XQ_W;

   typedef struct packed {
      logic               v;
      tss_pkg::endp_type  lo;
      tss_pkg::endp_type  hi;
      logic signed [15:0] row;
   } ord_type;

   typedef struct packed {
      logic               v;
      logic signed [31:0] left_x;
      logic [15:0]        left_z;
      logic [15:0]        left_l;
      logic signed [31:0] right_x;
      logic [15:0]        right_z;
      logic [15:0]        right_l;
      logic signed [15:0] row;
   } out_type;

   logic [63:0]          vertex_a_ff;
   logic [63:0]          vertex_b_ff;
   logic [63:0]          vertex_c_ff;
   logic signed [31:0]   slope_ab_ff;
   logic signed [31:0]   slope_bc_ff;
   logic signed [31:0]   slope_ac_ff;
   tss_pkg::vtx_type     va, vb, vc;
   tss_pkg::lane_in_type short_in, long_in;
   logic                 en;
   logic                 vs, vl;
   tss_pkg::endp_type    es, el;
   logic signed [15:0]   row_s;
   logic signed [15:0]   row_l;
   ord_type              ord_in, ord_ff;
   out_type              out_in, out_ff;

   // Slot extraction: low CW bits of x and y sign-extended, low AW bits of attributes.
   function automatic tss_pkg::vtx_type unpack(input logic [63:0] w);
      tss_pkg::vtx_type r;
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      logic [AW-1:0] zs;
      logic [AW-1:0] ls;
      xs = w[48 +: CW];
      ys = w[32 +: CW];
      zs = w[16 +: AW];
      ls = w[0 +: AW];
      r.x = tss_pkg::SLOT_W'(xs);
      r.y = tss_pkg::SLOT_W'(ys);
      r.z = tss_pkg::SLOT_W'(zs);
      r.l = tss_pkg::SLOT_W'(ls);
      return r;
   endfunction

   // Saturation of an unsaturated Q34.16 x to a 32-bit Q16.16 x.
   function automatic logic signed [31:0] sat32(input logic signed [XQ_W-1:0] v);
      logic signed [31:0] r;
      if ((&v[XQ_W-1:31]) || !(|v[XQ_W-1:31])) begin
         r = v[31:0];
      end else if (v[XQ_W-1]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

   // Configuration register writes.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_a_ff <= '0;
         vertex_b_ff <= '0;
         vertex_c_ff <= '0;
         slope_ab_ff <= '0;
         slope_bc_ff <= '0;
         slope_ac_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tss_pkg::REG_VERTEX_A: vertex_a_ff <= csr_wdata;
            tss_pkg::REG_VERTEX_B: vertex_b_ff <= csr_wdata;
            tss_pkg::REG_VERTEX_C: vertex_c_ff <= csr_wdata;
            tss_pkg::REG_SLOPE_AB: slope_ab_ff <= csr_wdata[31:0];
            tss_pkg::REG_SLOPE_BC: slope_bc_ff <= csr_wdata[31:0];
            tss_pkg::REG_SLOPE_AC: slope_ac_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // The pipeline advances unless a finished result is held by the receiver.
   assign en        = !(out_ff.v && rsp_stall);
   assign req_stall = !en;

   // Edge selection: the short edge switches from a-b to b-c at vertex b's row.
   always_comb begin
      va = unpack(vertex_a_ff);
      vb = unpack(vertex_b_ff);
      vc = unpack(vertex_c_ff);
      if (req_scan_y < vb.y) begin
         short_in.p     = va;
         short_in.q     = vb;
         short_in.slope = slope_ab_ff;
      end else begin
         short_in.p     = vb;
         short_in.q     = vc;
         short_in.slope = slope_bc_ff;
      end
      short_in.org_x = vb.x;
      short_in.org_y = vb.y;
      short_in.row   = req_scan_y;
      long_in.p      = va;
      long_in.q      = vc;
      long_in.org_x  = va.x;
      long_in.org_y  = va.y;
      long_in.slope  = slope_ac_ff;
      long_in.row    = req_scan_y;
   end

   tss_lane u_short (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .lane_in   (short_in),
      .out_valid (vs),
      .out_ep    (es),
      .out_row   (row_s)
   );

   tss_lane u_long (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .lane_in   (long_in),
      .out_valid (vl),
      .out_ep    (el),
      .out_row   (row_l)
   );

   // Endpoint ordering; on equal x the short-edge endpoint stays left.
   always_comb begin
      ord_in.v   = vs;
      ord_in.row = row_s;
      if (es.xq > el.xq) begin
         ord_in.lo = el;
         ord_in.hi = es;
      end else begin
         ord_in.lo = es;
         ord_in.hi = el;
      end
   end

   // Output register with saturated x.
   always_comb begin
      out_in.v       = ord_ff.v;
      out_in.left_x  = sat32(ord_ff.lo.xq);
      out_in.left_z  = ord_ff.lo.z;
      out_in.left_l  = ord_ff.lo.l;
      out_in.right_x = sat32(ord_ff.hi.xq);
      out_in.right_z = ord_ff.hi.z;
      out_in.right_l = ord_ff.hi.l;
      out_in.row     = ord_ff.row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ord_ff.v <= 1'b0;
         out_ff.v <= 1'b0;
      end else if (en) begin
         ord_ff <= ord_in;
         out_ff <= out_in;
      end
   end

   assign rsp_valid       = out_ff.v;
   assign rsp_left_x      = out_ff.left_x;
   assign rsp_left_depth  = out_ff.left_z;
   assign rsp_left_light  = out_ff.left_l;
   assign rsp_right_x     = out_ff.right_x;
   assign rsp_right_depth = out_ff.right_z;
   assign rsp_right_light = out_ff.right_l;
   assign rsp_row_out     = out_ff.row;

   // Delivered spans are ordered left to right.
   `TSS_ASSERT_IMP(a_span_order, clock, reset, rsp_valid, rsp_left_x <= rsp_right_x)
   // Reset empties the output stage.
   `TSS_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   // Both lanes carry the same transaction at the same time.
   `TSS_ASSERT_IMP(a_lane_align, clock, reset, vs || vl, vs && vl)
   // Both lanes deliver the same row.
   `TSS_ASSERT_IMP(a_row_align, clock, reset, vs, row_s == row_l)
endmodule
`default_nettype wire
